// File: src/dmwbc_pkg.sv
// Shared types and constants for the direct-mapped write-back cache.
package dmwbc_pkg;

	localparam int CACHE_LINES_DEF = 32;
	localparam int MEM_WORDS_DEF   = 65536;

	localparam int FUNC_W   = 2;
	localparam int ADDR_IN_W = 16;
	localparam int DATA_W   = 16;
	localparam int CNT_W    = 32;

	localparam logic [FUNC_W-1:0] FN_READ    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_WRITE   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_PRELOAD = 2'd2;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP
	} state_t;

endpackage

// File: src/dmwbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmwbc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/direct_mapped_writeback_cache_top.sv
// Top level of the direct-mapped write-back cache with its backing memory.
//
//   beat     handshake              payload
//   access   start in, busy out     func, address, write_data
//   result   done out (one cycle)   read_data, hit, wrote_back, memory_reads,
//                                   memory_writes, hit_count, miss_count
//
// An access reads the cache line and the backing word as it is accepted, then
// compares and updates cache line, backing word and counters as its function
// needs. Its result beat comes in the cycle after the compare, while the next
// access may already be accepted. After reset a clearing pass over all backing
// addresses zeroes those words and the cache entries; busy stays high during it.
// The receiver cannot stall; CACHE_LINES and MEM_WORDS are powers of two
// with CACHE_LINES below MEM_WORDS.
module direct_mapped_writeback_cache_top #(
	parameter int CACHE_LINES = dmwbc_pkg::CACHE_LINES_DEF,
	parameter int MEM_WORDS   = dmwbc_pkg::MEM_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [dmwbc_pkg::FUNC_W-1:0]    func,
	input  logic [dmwbc_pkg::ADDR_IN_W-1:0] address,
	input  logic [dmwbc_pkg::DATA_W-1:0]    write_data,
	output logic                           done,
	output logic [dmwbc_pkg::DATA_W-1:0]    read_data,
	output logic                           hit,
	output logic                           wrote_back,
	output logic [dmwbc_pkg::CNT_W-1:0]     memory_reads,
	output logic [dmwbc_pkg::CNT_W-1:0]     memory_writes,
	output logic [dmwbc_pkg::CNT_W-1:0]     hit_count,
	output logic [dmwbc_pkg::CNT_W-1:0]     miss_count
);

	import dmwbc_pkg::*;

	localparam int IDX_W   = $clog2(CACHE_LINES);
	localparam int ADDR_W  = $clog2(MEM_WORDS);
	localparam int TAG_W   = ADDR_W - IDX_W;
	localparam int ENTRY_W = 2 + TAG_W + DATA_W;

	typedef struct packed {
		logic              valid;
		logic              dirty;
		logic [TAG_W-1:0]  tag;
		logic [DATA_W-1:0] data;
	} entry_t;

	state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [FUNC_W-1:0] func_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] wdata_q;

	logic [CNT_W-1:0] fill_cnt_q, wb_cnt_q, hit_cnt_q, miss_cnt_q;
	logic              done_q, hit_q, wb_q;
	logic [DATA_W-1:0] rd_data_q;

	logic              accept;
	logic              clr_last;
	logic              clr_cache;
	logic [IDX_W-1:0]  idx;
	logic [TAG_W-1:0]  tag;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;
	logic              cache_we;
	logic [IDX_W-1:0]  cache_waddr, cache_raddr;
	entry_t            cache_wdata, cache_rdata;
	logic [ENTRY_W-1:0] cache_rbits;

	logic              hit_c, wb_c;
	logic [DATA_W-1:0] rdata_c;
	logic              fill_inc, hit_inc, miss_inc;

	assign accept    = start && (state_q == S_IDLE);
	assign clr_last  = (clr_q == ADDR_W'(MEM_WORDS - 1));
	assign clr_cache = ({1'b0, clr_q} < (ADDR_W + 1)'(CACHE_LINES));
	assign idx       = addr_q[IDX_W-1:0];
	assign tag       = addr_q[ADDR_W-1:IDX_W];
	assign cache_rdata = entry_t'(cache_rbits);

	dmwbc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MEM_WORDS)
	) u_mem_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	dmwbc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CACHE_LINES)
	) u_cache_ram (
		.clk  (clk),
		.we   (cache_we),
		.waddr(cache_waddr),
		.wdata(cache_wdata),
		.raddr(cache_raddr),
		.rdata(cache_rbits)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = addr_q;
		mem_wdata   = wdata_q;
		mem_raddr   = address[ADDR_W-1:0];
		cache_we    = 1'b0;
		cache_waddr = idx;
		cache_wdata = '0;
		cache_raddr = address[IDX_W-1:0];
		hit_c       = 1'b0;
		wb_c        = 1'b0;
		rdata_c     = '0;
		fill_inc    = 1'b0;
		hit_inc     = 1'b0;
		miss_inc    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we      = 1'b1;
				mem_waddr   = clr_q;
				mem_wdata   = '0;
				cache_we    = clr_cache;
				cache_waddr = clr_q[IDX_W-1:0];
			end
			S_LOOKUP: begin
				case (func_q)
					FN_READ: begin
						if (cache_rdata.valid && cache_rdata.tag == tag) begin
							hit_c   = 1'b1;
							rdata_c = cache_rdata.data;
							hit_inc = 1'b1;
						end else begin
							wb_c              = cache_rdata.valid && cache_rdata.dirty;
							mem_we            = wb_c;
							mem_waddr         = {cache_rdata.tag, idx};
							mem_wdata         = cache_rdata.data;
							cache_we          = 1'b1;
							cache_wdata.valid = 1'b1;
							cache_wdata.dirty = 1'b0;
							cache_wdata.tag   = tag;
							cache_wdata.data  = mem_rdata;
							rdata_c           = mem_rdata;
							fill_inc          = 1'b1;
							miss_inc          = 1'b1;
						end
					end
					FN_WRITE: begin
						wb_c = cache_rdata.valid && cache_rdata.dirty &&
							(cache_rdata.tag != tag);
						mem_we            = wb_c;
						mem_waddr         = {cache_rdata.tag, idx};
						mem_wdata         = cache_rdata.data;
						cache_we          = 1'b1;
						cache_wdata.valid = 1'b1;
						cache_wdata.dirty = 1'b1;
						cache_wdata.tag   = tag;
						cache_wdata.data  = wdata_q;
					end
					FN_PRELOAD: begin
						mem_we = 1'b1;
					end
					default: begin
						mem_we = 1'b0;
					end
				endcase
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			fill_cnt_q <= '0;
			wb_cnt_q   <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
			wb_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (fill_inc && fill_cnt_q != '1) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end
			if (wb_c && wb_cnt_q != '1) begin
				wb_cnt_q <= wb_cnt_q + 1'b1;
			end
			if (hit_inc && hit_cnt_q != '1) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end
			if (miss_inc && miss_cnt_q != '1) begin
				miss_cnt_q <= miss_cnt_q + 1'b1;
			end
			done_q <= (state_q == S_LOOKUP);
			hit_q  <= hit_c;
			wb_q   <= wb_c;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			addr_q  <= address[ADDR_W-1:0];
			wdata_q <= write_data;
		end
		if (state_q == S_LOOKUP) begin
			rd_data_q <= rdata_c;
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign read_data     = rd_data_q;
	assign hit           = hit_q;
	assign wrote_back    = wb_q;
	assign memory_reads  = fill_cnt_q;
	assign memory_writes = wb_cnt_q;
	assign hit_count     = hit_cnt_q;
	assign miss_count    = miss_cnt_q;

	a_done_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_LOOKUP))
		else $error("result beat without a lookup");

	a_hit_xor_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(hit || wrote_back) |-> (done && !(hit && wrote_back)))
		else $error("hit or write-back flag outside a result beat");

	a_wb_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(done && wrote_back) |->
			((memory_writes != $past(memory_writes)) || (memory_writes == '1)))
		else $error("write-back not counted");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |=> (state_q == S_CLEAR || state_q == S_IDLE))
		else $error("left the clearing pass into a lookup");

endmodule

// File: tb/direct_mapped_writeback_cache_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the write-back cache: directed and random accesses.
module direct_mapped_writeback_cache_top_tb;
	import dmwbc_pkg::*;

	localparam int IDX_W = $clog2(CACHE_LINES_DEF);
	localparam int TAG_W = ADDR_IN_W - IDX_W;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 600;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              hit;
		logic              wrote_back;
		logic [CNT_W-1:0]  memory_reads;
		logic [CNT_W-1:0]  memory_writes;
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  miss_count;
	} access_result_t;

	typedef struct packed {
		logic                 known;
		logic [FUNC_W-1:0]    op;
		logic [ADDR_IN_W-1:0] addr;
		logic [DATA_W-1:0]    wdata;
		access_result_t       result;
	} directed_row_t;

	localparam directed_row_t DIRECTED_ROWS [20] = '{
		'{1'b1, FN_READ,    16'h0000, 16'h0000, '{16'h0000, 1'b0, 1'b0, 1, 0, 0, 1}},
		'{1'b1, FN_READ,    16'h0000, 16'h0000, '{16'h0000, 1'b1, 1'b0, 1, 0, 1, 1}},
		'{1'b1, FN_PRELOAD, 16'hFFFF, 16'hFFFF, '{16'h0000, 1'b0, 1'b0, 1, 0, 1, 1}},
		'{1'b1, FN_READ,    16'hFFFF, 16'h0000, '{16'hFFFF, 1'b0, 1'b0, 2, 0, 1, 2}},
		'{1'b1, FN_WRITE,   16'h0020, 16'hA5A5, '{16'h0000, 1'b0, 1'b0, 2, 0, 1, 2}},
		'{1'b1, FN_WRITE,   16'h0040, 16'h5A5A, '{16'h0000, 1'b0, 1'b1, 2, 1, 1, 2}},
		'{1'b1, FN_WRITE,   16'h0040, 16'h1234, '{16'h0000, 1'b0, 1'b0, 2, 1, 1, 2}},
		'{1'b1, FN_READ,    16'h0040, 16'h0000, '{16'h1234, 1'b1, 1'b0, 2, 1, 2, 2}},
		'{1'b1, FN_READ,    16'h0020, 16'h0000, '{16'hA5A5, 1'b0, 1'b1, 3, 2, 2, 3}},
		'{1'b1, FN_READ,    16'h0040, 16'h0000, '{16'h1234, 1'b0, 1'b0, 4, 2, 2, 4}},
		'{1'b1, FN_PRELOAD, 16'h0040, 16'hBEEF, '{16'h0000, 1'b0, 1'b0, 4, 2, 2, 4}},
		'{1'b1, FN_READ,    16'h0040, 16'h0000, '{16'h1234, 1'b1, 1'b0, 4, 2, 3, 4}},
		'{1'b1, FN_UNUSED,  16'hFFFF, 16'hFFFF, '{16'h0000, 1'b0, 1'b0, 4, 2, 3, 4}},
		'{1'b0, FN_WRITE,   16'hFFFF, 16'h0000, '0},
		'{1'b0, FN_WRITE,   16'h001F, 16'hFFFF, '0},
		'{1'b0, FN_READ,    16'hFFFF, 16'h0000, '0},
		'{1'b0, FN_READ,    16'h001F, 16'h0000, '0},
		'{1'b1, FN_UNUSED,  16'h0000, 16'h0000, '{16'h0000, 1'b0, 1'b0, 6, 4, 3, 6}},
		'{1'b0, FN_WRITE,   16'h8001, 16'h8000, '0},
		'{1'b0, FN_READ,    16'h8001, 16'h0000, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [FUNC_W-1:0] func;
	logic [ADDR_IN_W-1:0] address;
	logic [DATA_W-1:0] write_data;
	logic done;
	logic [DATA_W-1:0] read_data;
	logic hit;
	logic wrote_back;
	logic [CNT_W-1:0] memory_reads;
	logic [CNT_W-1:0] memory_writes;
	logic [CNT_W-1:0] hit_count;
	logic [CNT_W-1:0] miss_count;

	logic              line_valid [CACHE_LINES_DEF];
	logic              line_dirty [CACHE_LINES_DEF];
	logic [TAG_W-1:0]  line_tag   [CACHE_LINES_DEF];
	logic [DATA_W-1:0] line_data  [CACHE_LINES_DEF];
	logic [DATA_W-1:0] backing_words [MEM_WORDS_DEF];
	logic [CNT_W-1:0]  fill_total;
	logic [CNT_W-1:0]  writeback_total;
	logic [CNT_W-1:0]  read_hit_total;
	logic [CNT_W-1:0]  read_miss_total;

	access_result_t pending_results [$];
	int error_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int beats_seen = 0;
	int hits_seen = 0;
	int writebacks_seen = 0;
	logic [TAG_W-1:0] tag_pool [4];

	direct_mapped_writeback_cache_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.address(address),
		.write_data(write_data),
		.done(done),
		.read_data(read_data),
		.hit(hit),
		.wrote_back(wrote_back),
		.memory_reads(memory_reads),
		.memory_writes(memory_writes),
		.hit_count(hit_count),
		.miss_count(miss_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic access_result_t predict_access(input logic [FUNC_W-1:0] op,
			input logic [ADDR_IN_W-1:0] addr, input logic [DATA_W-1:0] wdata);
		access_result_t r;
		logic [IDX_W-1:0] idx;
		logic [TAG_W-1:0] tg;
		r = '0;
		idx = addr[IDX_W-1:0];
		tg = addr[ADDR_IN_W-1:IDX_W];
		case (op)
			FN_READ: begin
				if (line_valid[idx] && line_tag[idx] == tg) begin
					r.hit = 1'b1;
					r.read_data = line_data[idx];
					read_hit_total = bump(read_hit_total);
				end else begin
					if (line_valid[idx] && line_dirty[idx]) begin
						backing_words[{line_tag[idx], idx}] = line_data[idx];
						writeback_total = bump(writeback_total);
						r.wrote_back = 1'b1;
					end
					line_valid[idx] = 1'b1;
					line_dirty[idx] = 1'b0;
					line_tag[idx] = tg;
					line_data[idx] = backing_words[addr];
					fill_total = bump(fill_total);
					read_miss_total = bump(read_miss_total);
					r.read_data = line_data[idx];
				end
			end
			FN_WRITE: begin
				if (line_valid[idx] && line_dirty[idx] && line_tag[idx] != tg) begin
					backing_words[{line_tag[idx], idx}] = line_data[idx];
					writeback_total = bump(writeback_total);
					r.wrote_back = 1'b1;
				end
				line_valid[idx] = 1'b1;
				line_dirty[idx] = 1'b1;
				line_tag[idx] = tg;
				line_data[idx] = wdata;
			end
			FN_PRELOAD: begin
				backing_words[addr] = wdata;
			end
			default: begin
			end
		endcase
		r.memory_reads = fill_total;
		r.memory_writes = writeback_total;
		r.hit_count = read_hit_total;
		r.miss_count = read_miss_total;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
			input logic [CNT_W-1:0] want);
		$display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	task automatic send_access(input logic [FUNC_W-1:0] op, input logic [ADDR_IN_W-1:0] addr,
			input logic [DATA_W-1:0] wdata, input logic known, input access_result_t known_result);
		access_result_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		func <= op;
		address <= addr;
		write_data <= wdata;
		do
			@(posedge clk);
		while (busy);
		predicted = predict_access(op, addr, wdata);
		pending_results.push_back(known ? known_result : predicted);
	endtask

	task automatic run_random_phase(input int count);
		logic [FUNC_W-1:0] op;
		logic [ADDR_IN_W-1:0] addr;
		int pick;
		foreach (tag_pool[i])
			tag_pool[i] = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				op = FN_READ;
			else if (pick < 75)
				op = FN_WRITE;
			else if (pick < 93)
				op = FN_PRELOAD;
			else
				op = FN_UNUSED;
			if ($urandom_range(0, 99) < 80)
				addr = {tag_pool[2'($urandom_range(0, 3))],
					IDX_W'($urandom_range(0, CACHE_LINES_DEF - 1))};
			else
				addr = ADDR_IN_W'($urandom);
			send_access(op, addr, DATA_W'($urandom), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && done) begin
			beats_seen++;
			hits_seen += int'(hit);
			writebacks_seen += int'(wrote_back);
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing expected", CNT_W'(read_data), '0);
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.read_data)
					report_mismatch("read_data", CNT_W'(read_data), CNT_W'(want.read_data));
				if (hit !== want.hit)
					report_mismatch("hit", CNT_W'(hit), CNT_W'(want.hit));
				if (wrote_back !== want.wrote_back)
					report_mismatch("wrote_back", CNT_W'(wrote_back), CNT_W'(want.wrote_back));
				if (memory_reads !== want.memory_reads)
					report_mismatch("memory_reads", memory_reads, want.memory_reads);
				if (memory_writes !== want.memory_writes)
					report_mismatch("memory_writes", memory_writes, want.memory_writes);
				if (hit_count !== want.hit_count)
					report_mismatch("hit_count", hit_count, want.hit_count);
				if (miss_count !== want.miss_count)
					report_mismatch("miss_count", miss_count, want.miss_count);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_READ;
		address = '0;
		write_data = '0;
		foreach (line_valid[i]) begin
			line_valid[i] = 1'b0;
			line_dirty[i] = 1'b0;
			line_tag[i] = '0;
			line_data[i] = '0;
		end
		foreach (backing_words[i])
			backing_words[i] = '0;
		fill_total = '0;
		writeback_total = '0;
		read_hit_total = '0;
		read_miss_total = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		sender_idle_pct = 33;
		foreach (DIRECTED_ROWS[i])
			send_access(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].wdata,
				DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].result);
		run_random_phase(ITEMS_PER_PHASE);
		sender_idle_pct = 69;
		run_random_phase(ITEMS_PER_PHASE);
		sender_idle_pct = 0;
		run_random_phase(ITEMS_PER_PHASE);

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d result beats (%0d read hits, %0d write-backs) in %0d cycles.",
			beats_seen, hits_seen, writebacks_seen, cycle_count);
		$display("Final counters: fills %0d, write-backs %0d, hits %0d, misses %0d; %0d mismatches.",
			fill_total, writeback_total, read_hit_total, read_miss_total,
			error_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
src/dmwbc_pkg.sv
src/dmwbc_ram.sv
src/direct_mapped_writeback_cache_top.sv
tb/direct_mapped_writeback_cache_top_tb.sv
